[design/mkd_pkg.sv]
// ----------------------------------------------------------------------------
// Morse key decoder package
// Shared types, widths and the character lookup for the key timing decoder.
// ----------------------------------------------------------------------------
package mkd_pkg;

    localparam int unsigned LimitW   = 16;   // width of a timing register
    localparam int unsigned TickW    = 18;   // tick counter, holds 3 * dot limit
    localparam int unsigned BitsW    = 5;    // element bits kept for the lookup
    localparam int unsigned CountW   = 3;    // element counter
    localparam int unsigned LetterW  = 7;
    localparam int unsigned CfgIdxW  = 4;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgDotLimit = 4'd0;
    localparam logic [CfgIdxW-1:0] CfgDashGap  = 4'd1;

    // Reset values of the timing registers
    localparam logic [LimitW-1:0] DotLimitRst = 16'h4000;
    localparam logic [TickW-1:0]  DotWaitRst  = 18'h0C000;   // 3 * DotLimitRst
    localparam logic [LimitW-1:0] DashGapRst  = 16'hF000;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TIMING,
        PH_WAIT_DOT,
        PH_WAIT_DASH
    } t_phase;

    // Symbol closed by the timing FSM
    typedef struct packed {
        logic              close;
        logic [BitsW-1:0]  bits;
        logic [CountW-1:0] count;
    } t_sym;

    // One result item
    typedef struct packed {
        logic [LetterW-1:0] letter;
        logic               known;
        logic [BitsW-1:0]   pattern;
        logic [CountW-1:0]  length;
    } t_result;

    // Morse table for A-Z and 0-9: key is {length, bits}, first element in
    // bit 0, dash = 1. Returns {known, letter}; unknown symbols give zero.
    function automatic logic [LetterW:0] lookup(input logic [CountW-1:0] len,
                                               input logic [BitsW-1:0]  bits);
        logic [LetterW:0] res;
        res = '0;
        unique case ({len, bits})
            {3'd2, 5'd2}:  res = {1'b1, 7'd65};  // A .-
            {3'd4, 5'd1}:  res = {1'b1, 7'd66};  // B -...
            {3'd4, 5'd5}:  res = {1'b1, 7'd67};  // C -.-.
            {3'd3, 5'd1}:  res = {1'b1, 7'd68};  // D -..
            {3'd1, 5'd0}:  res = {1'b1, 7'd69};  // E .
            {3'd4, 5'd4}:  res = {1'b1, 7'd70};  // F ..-.
            {3'd3, 5'd3}:  res = {1'b1, 7'd71};  // G --.
            {3'd4, 5'd0}:  res = {1'b1, 7'd72};  // H ....
            {3'd2, 5'd0}:  res = {1'b1, 7'd73};  // I ..
            {3'd4, 5'd14}: res = {1'b1, 7'd74};  // J .---
            {3'd3, 5'd5}:  res = {1'b1, 7'd75};  // K -.-
            {3'd4, 5'd2}:  res = {1'b1, 7'd76};  // L .-..
            {3'd2, 5'd3}:  res = {1'b1, 7'd77};  // M --
            {3'd2, 5'd1}:  res = {1'b1, 7'd78};  // N -.
            {3'd3, 5'd7}:  res = {1'b1, 7'd79};  // O ---
            {3'd4, 5'd6}:  res = {1'b1, 7'd80};  // P .--.
            {3'd4, 5'd11}: res = {1'b1, 7'd81};  // Q --.-
            {3'd3, 5'd2}:  res = {1'b1, 7'd82};  // R .-.
            {3'd3, 5'd0}:  res = {1'b1, 7'd83};  // S ...
            {3'd1, 5'd1}:  res = {1'b1, 7'd84};  // T -
            {3'd3, 5'd4}:  res = {1'b1, 7'd85};  // U ..-
            {3'd4, 5'd8}:  res = {1'b1, 7'd86};  // V ...-
            {3'd3, 5'd6}:  res = {1'b1, 7'd87};  // W .--
            {3'd4, 5'd9}:  res = {1'b1, 7'd88};  // X -..-
            {3'd4, 5'd13}: res = {1'b1, 7'd89};  // Y -.--
            {3'd4, 5'd3}:  res = {1'b1, 7'd90};  // Z --..
            {3'd5, 5'd31}: res = {1'b1, 7'd48};  // 0 -----
            {3'd5, 5'd30}: res = {1'b1, 7'd49};  // 1 .----
            {3'd5, 5'd28}: res = {1'b1, 7'd50};  // 2 ..---
            {3'd5, 5'd24}: res = {1'b1, 7'd51};  // 3 ...--
            {3'd5, 5'd16}: res = {1'b1, 7'd52};  // 4 ....-
            {3'd5, 5'd0}:  res = {1'b1, 7'd53};  // 5 .....
            {3'd5, 5'd1}:  res = {1'b1, 7'd54};  // 6 -....
            {3'd5, 5'd3}:  res = {1'b1, 7'd55};  // 7 --...
            {3'd5, 5'd7}:  res = {1'b1, 7'd56};  // 8 ---..
            {3'd5, 5'd15}: res = {1'b1, 7'd57};  // 9 ----.
            default:       res = '0;
        endcase
        return res;
    endfunction

endpackage

[design/mkd_fsm.sv]
// ----------------------------------------------------------------------------
// Morse key timing FSM
// Tracks key edges, times presses and gaps, collects elements and flags the
// closing of a symbol on the transfer that ends it.
// ----------------------------------------------------------------------------
module mkd_fsm #(
    parameter int unsigned MAX_ELEMENTS = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_action,
    input  logic                        i_key_down,
    input  logic [mkd_pkg::LimitW-1:0]  i_dot_limit,
    input  logic [mkd_pkg::TickW-1:0]   i_dot_wait,
    input  logic [mkd_pkg::LimitW-1:0]  i_dash_gap,
    output mkd_pkg::t_sym               o_sym
);

    localparam logic [mkd_pkg::CountW-1:0] MaxCount = mkd_pkg::CountW'(MAX_ELEMENTS);

    mkd_pkg::t_phase                r_phase, n_phase;
    logic [mkd_pkg::TickW-1:0]      r_tick, n_tick;
    logic [mkd_pkg::CountW-1:0]     r_count, n_count;
    logic [mkd_pkg::BitsW-1:0]      r_bits, n_bits;
    logic                           r_key, n_key;

    logic                           started;
    logic                           close;
    logic [mkd_pkg::TickW-1:0]      tick_inc;
    logic [mkd_pkg::CountW-1:0]     count_inc;
    logic [mkd_pkg::TickW-1:0]      limit;

    assign tick_inc  = r_tick + 1'b1;
    assign count_inc = r_count + 1'b1;

    // Limit of the running phase
    always_comb begin
        unique case (r_phase)
            mkd_pkg::PH_TIMING:   limit = mkd_pkg::TickW'(i_dot_limit);
            mkd_pkg::PH_WAIT_DOT: limit = i_dot_wait;
            default:              limit = mkd_pkg::TickW'(i_dash_gap);
        endcase
    end

    // Next state and symbol close
    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_count = r_count;
        n_bits  = r_bits;
        n_key   = r_key;
        started = 1'b0;
        close   = 1'b0;

        if (i_accept && i_action) begin
            n_phase = mkd_pkg::PH_IDLE;
            n_tick  = '0;
            n_count = '0;
            n_bits  = '0;
        end else if (i_accept) begin
            // key edges first
            if (i_key_down != r_key) begin
                n_key = i_key_down;
                if (i_key_down) begin
                    n_phase = mkd_pkg::PH_TIMING;
                    n_tick  = '0;
                    started = 1'b1;
                end else if (r_phase == mkd_pkg::PH_TIMING) begin
                    n_count = count_inc;
                    if (count_inc >= MaxCount) begin
                        close = 1'b1;
                    end else begin
                        n_phase = mkd_pkg::PH_WAIT_DOT;
                        n_tick  = '0;
                        started = 1'b1;
                    end
                end
            end

            // phase timer
            if (!close && !started && r_phase != mkd_pkg::PH_IDLE) begin
                n_tick = tick_inc;
                if (tick_inc >= limit) begin
                    if (i_key_down) begin
                        n_count = count_inc;
                        n_bits  = r_bits | (mkd_pkg::BitsW'(1) << r_count);
                        if (count_inc >= MaxCount) begin
                            close = 1'b1;
                        end else begin
                            n_phase = mkd_pkg::PH_WAIT_DASH;
                            n_tick  = '0;
                        end
                    end else begin
                        close = 1'b1;
                    end
                end
            end
        end

        o_sym.close = close;
        o_sym.bits  = n_bits;
        o_sym.count = n_count;

        // closing a symbol clears it
        if (close) begin
            n_phase = mkd_pkg::PH_IDLE;
            n_tick  = '0;
            n_count = '0;
            n_bits  = '0;
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mkd_pkg::PH_IDLE;
            r_tick  <= '0;
            r_count <= '0;
            r_bits  <= '0;
            r_key   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_count <= n_count;
            r_bits  <= n_bits;
            r_key   <= n_key;
        end
    end

    // A full symbol always closes, so the count stays below the maximum
    a_count_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < MaxCount)
        else $error("element count reached the maximum without closing");

    // Idle means no symbol and no timing in progress
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == mkd_pkg::PH_IDLE |-> (r_tick == '0 && r_count == '0 && r_bits == '0))
        else $error("idle phase holds stale symbol or tick state");

    // A closed symbol has at least one element
    a_close_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sym.close |-> (o_sym.count != '0 && o_sym.count <= MaxCount))
        else $error("closed symbol with bad length");

    // After a close the FSM is idle
    a_close_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sym.close |=> r_phase == mkd_pkg::PH_IDLE)
        else $error("FSM not idle after symbol close");

endmodule

[design/mkd_lookup.sv]
// ----------------------------------------------------------------------------
// Morse symbol lookup
// Maps a closed symbol to its character and builds the result item.
// ----------------------------------------------------------------------------
module mkd_lookup (
    input  mkd_pkg::t_sym     i_sym,
    output mkd_pkg::t_result  o_result
);

    logic [mkd_pkg::LetterW:0] hit;

    // Table lookup on {length, bits}
    assign hit = mkd_pkg::lookup(i_sym.count, i_sym.bits);

    assign o_result.letter  = hit[mkd_pkg::LetterW-1:0];
    assign o_result.known   = hit[mkd_pkg::LetterW];
    assign o_result.pattern = i_sym.bits;
    assign o_result.length  = i_sym.count;

endmodule

[design/mkd_out_buf.sv]
// ----------------------------------------------------------------------------
// Result output buffer
// Output register plus one skid entry, so the input side keeps taking items
// while a result waits for the receiver.
// ----------------------------------------------------------------------------
module mkd_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mkd_pkg::t_result   i_result,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_ready,
    output mkd_pkg::t_result   o_result
);

    logic              r_out_valid;
    logic              r_skid_valid;
    mkd_pkg::t_result  r_out;
    mkd_pkg::t_result  r_skid;
    logic              pop;

    assign pop      = r_out_valid & i_ready;
    assign o_space  = ~r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (pop) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (i_push && r_out_valid && !pop) begin
                r_skid_valid <= 1'b1;
            end
            if (i_push || r_skid_valid) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: the skid entry drains first, a new result fills the gap
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || pop) begin
                r_out <= i_result;
            end else begin
                r_skid <= i_result;
            end
        end
    end

    // The skid entry is only used behind a waiting output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds data while output is empty");

    // No push arrives while the skid entry is occupied
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("result pushed into a full buffer");

    // A stalled output with a push behind it fills the skid entry
    a_skid_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_out_valid && !i_ready) |=> r_skid_valid)
        else $error("result lost behind a stalled output");

endmodule

[design/morse_key_timing_decoder.sv]
// ----------------------------------------------------------------------------
// Morse key timing decoder
// Decodes a sampled Morse key into characters A-Z and 0-9.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready): one transfer per timer tick carrying
//   the key sample (i_action = 0), or a clear of the current symbol
//   (i_action = 1). Output channel (o_valid / i_ready): one result per
//   closed symbol: letter, known flag, element pattern and length.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sets
//   the dot limit, index 1 the dash gap; other indexes are dropped. Write
//   only while the decoder has no result pending.
//   Throughput: one input transfer per cycle while o_ready is high. The tick
//   counter update, element FSM and table lookup are combinational logic,
//   ahead of the result register.
//   Output: the result of the tick that closes the symbol is registered in
//   the output register, or in the skid entry while the output waits.
//   Stall: an output register and one skid entry hold results; o_ready
//   drops only while both are full.
//   Reset: synchronous, active low; symbol cleared, key taken as released,
//   limits back to their defaults.
// ----------------------------------------------------------------------------
module morse_key_timing_decoder #(
    parameter int unsigned MAX_ELEMENTS = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic                          i_key_down,
    // results
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mkd_pkg::LetterW-1:0]   o_letter,
    output logic                          o_known,
    output logic [mkd_pkg::BitsW-1:0]     o_pattern,
    output logic [mkd_pkg::CountW-1:0]    o_length,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mkd_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [mkd_pkg::LimitW-1:0]    i_cfg_data
);

    logic [mkd_pkg::LimitW-1:0]  r_dot_limit;
    logic [mkd_pkg::TickW-1:0]   r_dot_wait;
    logic [mkd_pkg::LimitW-1:0]  r_dash_gap;
    logic                        cfg_we;
    logic                        accept;
    logic                        space;
    mkd_pkg::t_sym               sym;
    mkd_pkg::t_result            result;
    mkd_pkg::t_result            out_result;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign o_ready     = space;
    assign accept      = i_valid & space;

    // Timing registers; the dot wait (3x dot limit) is kept precomputed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot_limit <= mkd_pkg::DotLimitRst;
            r_dot_wait  <= mkd_pkg::DotWaitRst;
            r_dash_gap  <= mkd_pkg::DashGapRst;
        end else if (cfg_we) begin
            if (i_cfg_index == mkd_pkg::CfgDotLimit) begin
                r_dot_limit <= i_cfg_data;
                r_dot_wait  <= {1'b0, i_cfg_data, 1'b0} + {2'b00, i_cfg_data};
            end else if (i_cfg_index == mkd_pkg::CfgDashGap) begin
                r_dash_gap  <= i_cfg_data;
            end
        end
    end

    mkd_fsm #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_action    (i_action),
        .i_key_down  (i_key_down),
        .i_dot_limit (r_dot_limit),
        .i_dot_wait  (r_dot_wait),
        .i_dash_gap  (r_dash_gap),
        .o_sym       (sym)
    );

    mkd_lookup u_lookup (
        .i_sym    (sym),
        .o_result (result)
    );

    mkd_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (sym.close),
        .i_result (result),
        .o_space  (space),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_result)
    );

    assign o_letter  = out_result.letter;
    assign o_known   = out_result.known;
    assign o_pattern = out_result.pattern;
    assign o_length  = out_result.length;

endmodule

[bench/mkd_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse key decoder bench package
// Codes and sizes shared by the decoder checker and the bench top.
// ----------------------------------------------------------------------------
package mkd_tb_pkg;

    // Input item kinds
    localparam logic ActTick  = 1'b0;   // timer tick with key sample
    localparam logic ActClear = 1'b1;   // drop symbol and timing

    // Elements per symbol before it closes on its own
    localparam int unsigned MaxElements = 5;

endpackage

[bench/morse_symbol_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse symbol checker
// Watches the input, result and register channels of the key timing decoder,
// runs its own model of the key timing and character lookup on each accepted
// tick, and compares every result transfer against the oldest letter due.
// ----------------------------------------------------------------------------
module morse_symbol_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_ready_in,
    input  logic                          i_action,
    input  logic                          i_key_down,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  logic [mkd_pkg::LetterW-1:0]   i_letter,
    input  logic                          i_known,
    input  logic [mkd_pkg::BitsW-1:0]     i_pattern,
    input  logic [mkd_pkg::CountW-1:0]    i_length,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [mkd_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [mkd_pkg::LimitW-1:0]    i_cfg_data,
    output int unsigned                   o_due,
    output int unsigned                   o_errors
);

    localparam int          CharA       = "A";
    localparam int          CharZero    = "0";
    localparam byte         DashMark    = "-";

    // model state
    mkd_pkg::t_phase                phase;
    logic [mkd_pkg::TickW-1:0]      ticks;
    logic [mkd_pkg::CountW-1:0]     n_elem;
    logic [mkd_pkg::BitsW-1:0]      elem_bits;
    logic                           key_prev;
    logic [mkd_pkg::LimitW-1:0]     dot_lim;
    logic [mkd_pkg::LimitW-1:0]     gap_lim;

    mkd_pkg::t_result    due_letters[$];
    int unsigned         err_cnt = 0;

    // Morse code of letters A-Z then digits 0-9
    function automatic string morse_code(input int idx);
        case (idx)
            0:  return ".-";
            1:  return "-...";
            2:  return "-.-.";
            3:  return "-..";
            4:  return ".";
            5:  return "..-.";
            6:  return "--.";
            7:  return "....";
            8:  return "..";
            9:  return ".---";
            10: return "-.-";
            11: return ".-..";
            12: return "--";
            13: return "-.";
            14: return "---";
            15: return ".--.";
            16: return "--.-";
            17: return ".-.";
            18: return "...";
            19: return "-";
            20: return "..-";
            21: return "...-";
            22: return ".--";
            23: return "-..-";
            24: return "-.--";
            25: return "--..";
            26: return "-----";
            27: return ".----";
            28: return "..---";
            29: return "...--";
            30: return "....-";
            31: return ".....";
            32: return "-....";
            33: return "--...";
            34: return "---..";
            default: return "----.";
        endcase
    endfunction

    // {known, letter} of a closed symbol, zero when not in the table
    function automatic logic [mkd_pkg::LetterW:0] symbol_char(
        input logic [mkd_pkg::CountW-1:0] len,
        input logic [mkd_pkg::BitsW-1:0]  bits);
        string                       code;
        logic [mkd_pkg::BitsW-1:0]   shape;
        logic [mkd_pkg::LetterW-1:0] ch;
        logic [mkd_pkg::LetterW:0]   res;
        res = '0;
        for (int i = 0; i < 36; i++) begin
            code  = morse_code(i);
            shape = '0;
            for (int k = 0; k < code.len(); k++)
                if (code[k] == DashMark)
                    shape[k] = 1'b1;
            if (code.len() == len && shape == bits) begin
                ch  = mkd_pkg::LetterW'((i < 26) ? CharA + i : CharZero + i - 26);
                res = {1'b1, ch};
            end
        end
        return res;
    endfunction

    task automatic clear_symbol();
        phase     = mkd_pkg::PH_IDLE;
        ticks     = '0;
        n_elem    = '0;
        elem_bits = '0;
    endtask

    // Look up the symbol, queue its letter and start over
    task automatic emit_symbol();
        logic [mkd_pkg::LetterW:0] hit;
        mkd_pkg::t_result          due;
        hit         = symbol_char(n_elem, elem_bits);
        due.letter  = hit[mkd_pkg::LetterW-1:0];
        due.known   = hit[mkd_pkg::LetterW];
        due.pattern = elem_bits;
        due.length  = n_elem;
        due_letters.push_back(due);
        clear_symbol();
    endtask

    // Append a dot or dash; true once the symbol is full
    function automatic bit append_element(input logic dash);
        if (dash && n_elem < mkd_pkg::BitsW)
            elem_bits[n_elem] = 1'b1;
        n_elem = n_elem + 1'b1;
        return n_elem >= mkd_tb_pkg::MaxElements;
    endfunction

    // One accepted item: key edges first, then the phase counter
    task automatic take_tick(input logic act, input logic key);
        logic                      started;
        logic [mkd_pkg::TickW-1:0] lim;
        started = 1'b0;
        if (act == mkd_tb_pkg::ActClear) begin
            clear_symbol();
        end else begin
            if (key != key_prev) begin
                key_prev = key;
                if (key) begin
                    phase   = mkd_pkg::PH_TIMING;
                    ticks   = '0;
                    started = 1'b1;
                end else if (phase == mkd_pkg::PH_TIMING) begin
                    if (append_element(1'b0)) begin
                        emit_symbol();
                    end else begin
                        phase   = mkd_pkg::PH_WAIT_DOT;
                        ticks   = '0;
                        started = 1'b1;
                    end
                end
            end
            if (!started && phase != mkd_pkg::PH_IDLE) begin
                ticks = ticks + 1'b1;
                case (phase)
                    mkd_pkg::PH_TIMING:   lim = mkd_pkg::TickW'(dot_lim);
                    mkd_pkg::PH_WAIT_DOT: lim = mkd_pkg::TickW'(3 * dot_lim);
                    default:              lim = mkd_pkg::TickW'(gap_lim);
                endcase
                if (ticks >= lim) begin
                    if (!key) begin
                        emit_symbol();
                    end else if (append_element(1'b1)) begin
                        emit_symbol();
                    end else begin
                        phase = mkd_pkg::PH_WAIT_DASH;
                        ticks = '0;
                    end
                end
            end
        end
    endtask

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v) begin
            err_cnt++;
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
        end
    endtask

    // Compare results first, then apply register writes and the new tick
    always @(posedge i_clk) begin : watch
        mkd_pkg::t_result got;
        mkd_pkg::t_result want;
        if (!i_rst_n) begin
            dot_lim  = mkd_pkg::DotLimitRst;
            gap_lim  = mkd_pkg::DashGapRst;
            key_prev = 1'b0;
            clear_symbol();
            due_letters.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = {i_letter, i_known, i_pattern, i_length};
                if (due_letters.size() == 0) begin
                    err_cnt++;
                    $error("result with no letter due: letter %0d pattern %0d length %0d",
                           got.letter, got.pattern, got.length);
                end else begin
                    want = due_letters.pop_front();
                    check_field("letter", 32'(want.letter), 32'(got.letter));
                    check_field("known", 32'(want.known), 32'(got.known));
                    check_field("pattern", 32'(want.pattern), 32'(got.pattern));
                    check_field("length", 32'(want.length), 32'(got.length));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == mkd_pkg::CfgDotLimit)
                    dot_lim = i_cfg_data;
                else if (i_cfg_index == mkd_pkg::CfgDashGap)
                    gap_lim = i_cfg_data;
            end
            if (i_valid && i_ready_in)
                take_tick(i_action, i_key_down);
        end
        o_due    <= due_letters.size();
        o_errors <= err_cnt;
    end

endmodule

[bench/morse_key_timing_decoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse key timing decoder bench
// Drives key ticks, clears and register writes into the decoder with random
// gaps and output stalls: short runs at the reset limits, directed symbols at
// small and zero limits, random key runs under changing limits, then short
// runs at the maximum limits. A checker beside the decoder predicts every
// letter; this top only drives and gives the verdict.
// ----------------------------------------------------------------------------
module morse_key_timing_decoder_tb;

    localparam int unsigned RandomItems = 650;
    localparam int unsigned StallLimit  = 2000;   // cycles with no transfer
    localparam int unsigned DrainCycles = 4;

    logic                          i_clk;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic                          o_ready;
    logic                          i_action    = mkd_tb_pkg::ActTick;
    logic                          i_key_down  = 1'b0;
    logic                          o_valid;
    logic                          i_ready     = 1'b0;
    logic [mkd_pkg::LetterW-1:0]   o_letter;
    logic                          o_known;
    logic [mkd_pkg::BitsW-1:0]     o_pattern;
    logic [mkd_pkg::CountW-1:0]    o_length;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [mkd_pkg::CfgIdxW-1:0]   i_cfg_index = mkd_pkg::CfgDotLimit;
    logic [mkd_pkg::LimitW-1:0]    i_cfg_data  = '0;

    int unsigned due_cnt;
    int unsigned err_cnt;
    int unsigned burst_left  = 0;
    int unsigned ready_hold  = 0;
    int unsigned idle_run    = 0;
    int unsigned random_sent = 0;
    bit          quiet       = 1'b0;   // no sender gaps during fixed runs
    logic        key_now     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    morse_key_timing_decoder #(
        .MAX_ELEMENTS (mkd_tb_pkg::MaxElements)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_key_down  (i_key_down),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_letter    (o_letter),
        .o_known     (o_known),
        .o_pattern   (o_pattern),
        .o_length    (o_length),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    morse_symbol_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_ready_in  (o_ready),
        .i_action    (i_action),
        .i_key_down  (i_key_down),
        .i_res_valid (o_valid),
        .i_res_ready (i_ready),
        .i_letter    (o_letter),
        .i_known     (o_known),
        .i_pattern   (o_pattern),
        .i_length    (o_length),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_due       (due_cnt),
        .o_errors    (err_cnt)
    );

    // Result side: long ready stretches, short and occasional long stalls
    always @(posedge i_clk) begin : result_sink
        int unsigned pick;
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                i_ready    <= 1'b1;
                ready_hold <= $urandom_range(0, 40);
            end else if (pick < 90) begin
                i_ready    <= 1'b0;
                ready_hold <= $urandom_range(0, 2);
            end else begin
                i_ready    <= 1'b0;
                ready_hold <= $urandom_range(3, 30);
            end
        end
    end

    // Watchdog: end the run when no channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= StallLimit) begin
            $display("morse_key_timing_decoder regression: fail");
            $finish;
        end
    end

    // One input transfer, after a random gap unless in a burst
    task automatic push_item(input logic act, input logic key);
        int unsigned gap;
        int unsigned pick;
        gap = 0;
        if (!quiet) begin
            if (burst_left != 0) begin
                burst_left--;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    burst_left = $urandom_range(20, 80);
                else if (pick < 55)
                    gap = 0;
                else if (pick < 92)
                    gap = $urandom_range(1, 3);
                else
                    gap = $urandom_range(4, 30);
            end
        end
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_action   <= act;
        i_key_down <= key;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // n ticks at one key level
    task automatic hold_key(input logic level, input int unsigned n);
        repeat (n) push_item(mkd_tb_pkg::ActTick, level);
        key_now = level;
    endtask

    // Stop sending and wait until every due letter has arrived
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (due_cnt != 0);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mkd_pkg::CfgIdxW-1:0] idx,
                             input logic [mkd_pkg::LimitW-1:0]  data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic new_limits(input int unsigned dot, input int unsigned gap);
        settle();
        write_reg(mkd_pkg::CfgDotLimit, mkd_pkg::LimitW'(dot));
        write_reg(mkd_pkg::CfgDashGap, mkd_pkg::LimitW'(gap));
    endtask

    initial begin : stimulus
        int unsigned dot;
        int unsigned gap;
        int unsigned pick;
        int unsigned block;
        int unsigned run;
        logic        level;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset limits: a dot wait and a long press, each cleared before expiry
        quiet = 1'b1;
        hold_key(1'b1, 1);
        hold_key(1'b0, 20);
        push_item(mkd_tb_pkg::ActClear, 1'b0);
        hold_key(1'b1, 20);
        hold_key(1'b0, 1);
        push_item(mkd_tb_pkg::ActClear, 1'b0);
        quiet = 1'b0;

        new_limits(2, 3);
        push_item(mkd_tb_pkg::ActClear, 1'b1);  // clear while idle
        hold_key(1'b1, 1);                  // single dot
        hold_key(1'b0, 8);
        hold_key(1'b1, 4);                  // single dash
        hold_key(1'b0, 5);
        hold_key(1'b1, 16);                 // held key: dashes until full
        hold_key(1'b0, 1);
        hold_key(1'b1, 1);                  // press during dot wait
        hold_key(1'b0, 2);
        hold_key(1'b1, 1);
        hold_key(1'b0, 8);
        repeat (5) begin                    // five dots close at once
            hold_key(1'b1, 1);
            hold_key(1'b0, 1);
        end
        hold_key(1'b1, 1);                  // clear mid-symbol, key level kept
        push_item(mkd_tb_pkg::ActClear, 1'b0);
        hold_key(1'b0, 8);                  // release outside timing
        repeat (2) begin                    // symbol not in the table
            hold_key(1'b1, 1);
            hold_key(1'b0, 1);
            hold_key(1'b1, 3);
            hold_key(1'b0, 1);
        end
        hold_key(1'b0, 3);

        // limit lowered under a running count
        new_limits(8, 3);
        hold_key(1'b1, 4);
        settle();
        write_reg(mkd_pkg::CfgDotLimit, mkd_pkg::LimitW'(1));
        hold_key(1'b1, 1);
        hold_key(1'b0, 4);

        // zero limits, then writes to unused indexes
        new_limits(0, 0);
        hold_key(1'b1, 3);
        hold_key(1'b0, 2);
        settle();
        for (int idx = mkd_pkg::CfgDashGap + 1; idx < (1 << mkd_pkg::CfgIdxW); idx++)
            write_reg(mkd_pkg::CfgIdxW'(idx), mkd_pkg::LimitW'($urandom));
        hold_key(1'b1, 1);
        hold_key(1'b0, 3);

        // random key runs under changing limits
        while (random_sent < RandomItems) begin
            pick = $urandom_range(0, 19);
            dot  = (pick == 0) ? 1 : (pick == 2) ? 0 : $urandom_range(1, 6);
            gap  = (pick == 1) ? 1 : $urandom_range(1, 10);
            new_limits(dot, gap);
            if ($urandom_range(0, 3) == 0)
                write_reg(mkd_pkg::CfgIdxW'($urandom_range(mkd_pkg::CfgDashGap + 1,
                                                           (1 << mkd_pkg::CfgIdxW) - 1)),
                          mkd_pkg::LimitW'($urandom));
            block = $urandom_range(40, 120);
            while (block > 0) begin
                if ($urandom_range(0, 24) == 0) begin
                    push_item(mkd_tb_pkg::ActClear, 1'($urandom_range(0, 1)));
                    run = 1;
                end else begin
                    level = !key_now;
                    if (level)
                        run = ($urandom_range(0, 9) < 7) ? $urandom_range(1, dot + 1)
                                                          : $urandom_range(dot + 1,
                                                                           dot + 2 * gap + 3);
                    else
                        run = ($urandom_range(0, 9) < 6) ? $urandom_range(1, dot + 1)
                                                          : $urandom_range(1,
                                                                           3 * dot + gap + 3);
                    hold_key(level, run);
                end
                block       = (block > run) ? block - run : 0;
                random_sent = random_sent + run;
            end
        end

        // maximum limits: a long press and a dot wait, each cleared before expiry
        new_limits(16'hFFFF, 16'hFFFF);
        quiet = 1'b1;
        hold_key(1'b1, 20);
        hold_key(1'b0, 1);
        push_item(mkd_tb_pkg::ActClear, 1'b0);
        hold_key(1'b1, 1);
        hold_key(1'b0, 20);
        push_item(mkd_tb_pkg::ActClear, 1'b0);
        quiet = 1'b0;

        settle();
        if (err_cnt == 0)
            $display("morse_key_timing_decoder regression: pass");
        else
            $display("morse_key_timing_decoder regression: fail");
        $finish;
    end

endmodule
